/* hw/rtl/pcs_pkg.sv */
package pcs_pkg;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INT_GAIN       = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_INTEGRAL_BOUND = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4,
        CFG_DERIV_MODE     = 3'd5,
        CFG_MIN_STEP       = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        DM_NONE  = 2'd0,
        DM_ERROR = 2'd1,
        DM_MEAS  = 2'd2,
        DM_RATE  = 2'd3
    } deriv_mode_t;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic signed [31:0] measured_rate;
        logic [30:0]        time_step;
        logic               clear_integral;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               saturated;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if ((&v[34:31]) || !(|v[34:31]))
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[34] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [32:0] t;
        t = -{v[31], v};
        return v[31] ? t[31:0] : v;
    endfunction

endpackage

/* hw/rtl/pcs_mul.sv */
module pcs_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               valid,
    output logic signed [31:0] res
);

    logic               stage1_valid_reg;
    logic               stage2_valid_reg;
    logic signed [63:0] prod;
    logic signed [63:0] prod_reg;
    logic signed [47:0] shifted;
    logic signed [31:0] res_reg;
    logic signed [31:0] res_next;

    assign prod    = a * b;
    assign shifted = prod_reg[63:16];

    always_comb
    begin
        if ((&shifted[47:31]) || !(|shifted[47:31]))
        begin
            res_next = shifted[31:0];
        end
        else
        begin
            res_next = shifted[47] ? pcs_pkg::Q_MIN : pcs_pkg::Q_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
        end
        else
        begin
            stage1_valid_reg <= start;
            stage2_valid_reg <= stage1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        res_reg  <= res_next;
    end

    assign valid = stage2_valid_reg;
    assign res   = res_reg;

endmodule

/* hw/rtl/pcs_div.sv */
module pcs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [30:0]        den,
    output logic               done,
    output logic signed [31:0] quo
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t         state_reg;
    logic               done_reg;
    logic signed [31:0] quo_reg;
    logic [30:0]        den_reg;
    logic [30:0]        rem_reg;
    logic [30:0]        sh_reg;
    logic [30:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic               neg_reg;

    logic [31:0] mag;
    logic [31:0] trial;
    logic        ge;
    logic [31:0] diff;
    logic [30:0] q_step;

    assign mag    = pcs_pkg::abs32(num);
    assign trial  = {rem_reg, sh_reg[30]};
    assign ge     = trial >= {1'b0, den_reg};
    assign diff   = trial - {1'b0, den_reg};
    assign q_step = {q_reg[29:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            quo_reg   <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            sh_reg    <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (den == '0)
                        begin
                            quo_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else if ({15'd0, mag[31:15]} >= {1'b0, den})
                        begin
                            quo_reg  <= num[31] ? pcs_pkg::Q_MIN : pcs_pkg::Q_MAX;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            den_reg   <= den;
                            rem_reg   <= {14'd0, mag[31:15]};
                            sh_reg    <= {mag[14:0], 16'd0};
                            q_reg     <= '0;
                            cnt_reg   <= 5'd31;
                            neg_reg   <= num[31];
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? diff[30:0] : trial[30:0];
                    sh_reg  <= {sh_reg[29:0], 1'b0};
                    q_reg   <= q_step;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        quo_reg   <= neg_reg ? -$signed({1'b0, q_step})
                                             : $signed({1'b0, q_step});
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* hw/rtl/pid_controller_step_unit.sv */
// PID step in signed Q16.16 with integral anti-windup. One item in gives one
// result item out. The unit is busy (sample_stall high) from acceptance until
// its result is placed in the output register, which holds it while the
// consumer stalls so that the next item can already be taken. When the error
// or measurement difference is divided by the time step (or by the minimum
// step, if that is larger), the serial divider takes 31 iterations; with no
// division the divider is skipped. Two to five multiplies go one after another
// through a single two-stage multiplier.
// Configuration writes are always ready and take effect at once; write them
// only while no item is in flight.
module pid_controller_step_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  pcs_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output pcs_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DIV,
        S_MISSUE,
        S_MWAIT,
        S_FIN
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_PROP,
        OP_DERIV,
        OP_STEP,
        OP_TRIAL,
        OP_HELD
    } mul_op_t;

    logic signed [31:0]   kp_reg;
    logic signed [31:0]   ki_reg;
    logic signed [31:0]   kd_reg;
    logic [30:0]          bound_reg;
    logic [30:0]          limit_reg;
    pcs_pkg::deriv_mode_t mode_reg;
    logic [30:0]          min_step_reg;

    seq_state_t         state_reg,    state_next;
    mul_op_t            op_reg,       op_next;
    logic signed [31:0] err_reg,      err_next;
    logic signed [31:0] nm_reg,       nm_next;
    logic signed [31:0] d_reg,        d_next;
    logic [30:0]        dt_reg,       dt_next;
    logic [30:0]        den_reg,      den_next;
    logic signed [31:0] num_reg,      num_next;
    logic signed [33:0] acc_reg,      acc_next;
    logic signed [31:0] cand_reg,     cand_next;
    logic               sat_reg,      sat_next;
    logic signed [31:0] integral_reg, integral_next;
    logic signed [31:0] prev_reg,     prev_next;
    logic               div_start_reg, div_start_next;
    logic               mul_start_reg, mul_start_next;
    logic signed [31:0] mul_a_reg,    mul_a_next;
    logic signed [31:0] mul_b_reg,    mul_b_next;
    logic               out_valid_reg, out_valid_next;
    pcs_pkg::result_t   out_item_reg, out_item_next;

    logic               div_done;
    logic signed [31:0] div_quo;
    logic               mul_valid;
    logic signed [31:0] mul_res;

    logic               ki_pos;
    logic signed [33:0] acc_sum;
    logic signed [31:0] trial;
    logic               hold;
    logic signed [31:0] diff_src;
    logic signed [31:0] drive_sat;
    logic signed [31:0] lim_s;
    logic signed [31:0] drive_clamped;

    pcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    pcs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .valid (mul_valid),
        .res   (mul_res)
    );

    assign ki_pos   = !ki_reg[31] && (ki_reg != '0);
    assign acc_sum  = acc_reg + 34'(mul_res);
    assign trial    = pcs_pkg::sat32(35'(acc_sum));
    assign hold     = ((limit_reg != '0) && (pcs_pkg::abs32(trial) > {1'b0, limit_reg}))
                      || (pcs_pkg::abs32(cand_reg) > {1'b0, bound_reg});
    assign diff_src = (mode_reg == pcs_pkg::DM_ERROR) ? err_reg : nm_reg;
    assign drive_sat = pcs_pkg::sat32(35'(acc_reg));
    assign lim_s    = $signed({1'b0, limit_reg});

    always_comb
    begin
        drive_clamped = drive_sat;
        if (limit_reg != '0)
        begin
            if (drive_sat > lim_s)
            begin
                drive_clamped = lim_s;
            end
            else if (drive_sat < -lim_s)
            begin
                drive_clamped = -lim_s;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        err_next       = err_reg;
        nm_next        = nm_reg;
        d_next         = d_reg;
        dt_next        = dt_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        acc_next       = acc_reg;
        cand_next      = cand_reg;
        sat_next       = sat_reg;
        integral_next  = integral_reg;
        prev_next      = prev_reg;
        div_start_next = 1'b0;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_item_next  = out_item_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    err_next = pcs_pkg::sat32(35'(sample.setpoint) - 35'(sample.measured));
                    nm_next  = pcs_pkg::sat32(-35'(sample.measured));
                    d_next   = (mode_reg == pcs_pkg::DM_RATE)
                               ? pcs_pkg::sat32(-35'(sample.measured_rate)) : '0;
                    dt_next  = sample.time_step;
                    den_next = (sample.time_step > min_step_reg) ? sample.time_step
                                                                 : min_step_reg;
                    sat_next = 1'b0;
                    if (sample.clear_integral)
                    begin
                        integral_next = '0;
                    end
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                if ((mode_reg == pcs_pkg::DM_ERROR) || (mode_reg == pcs_pkg::DM_MEAS))
                begin
                    num_next       = pcs_pkg::sat32(35'(diff_src) - 35'(prev_reg));
                    prev_next      = diff_src;
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
                else
                begin
                    op_next    = OP_PROP;
                    state_next = S_MISSUE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    d_next     = div_quo;
                    op_next    = OP_PROP;
                    state_next = S_MISSUE;
                end
            end
            S_MISSUE:
            begin
                case (op_reg)
                    OP_PROP:
                    begin
                        mul_a_next = err_reg;
                        mul_b_next = kp_reg;
                    end
                    OP_DERIV:
                    begin
                        mul_a_next = d_reg;
                        mul_b_next = kd_reg;
                    end
                    OP_STEP:
                    begin
                        mul_a_next = err_reg;
                        mul_b_next = $signed({1'b0, dt_reg});
                    end
                    OP_TRIAL:
                    begin
                        mul_a_next = cand_reg;
                        mul_b_next = ki_reg;
                    end
                    default:
                    begin
                        mul_a_next = integral_reg;
                        mul_b_next = ki_reg;
                    end
                endcase
                mul_start_next = 1'b1;
                state_next     = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mul_valid)
                begin
                    case (op_reg)
                        OP_PROP:
                        begin
                            acc_next   = 34'(mul_res);
                            op_next    = OP_DERIV;
                            state_next = S_MISSUE;
                        end
                        OP_DERIV:
                        begin
                            acc_next = acc_sum;
                            if (ki_pos)
                            begin
                                op_next    = OP_STEP;
                                state_next = S_MISSUE;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        OP_STEP:
                        begin
                            cand_next  = pcs_pkg::sat32(35'(integral_reg) + 35'(mul_res));
                            op_next    = OP_TRIAL;
                            state_next = S_MISSUE;
                        end
                        OP_TRIAL:
                        begin
                            if (hold)
                            begin
                                sat_next   = 1'b1;
                                op_next    = OP_HELD;
                                state_next = S_MISSUE;
                            end
                            else
                            begin
                                integral_next = cand_reg;
                                acc_next      = acc_sum;
                                state_next    = S_FIN;
                            end
                        end
                        default:
                        begin
                            acc_next   = acc_sum;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_item_next.drive     = drive_clamped;
                    out_item_next.saturated = sat_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PROP;
            err_reg       <= '0;
            nm_reg        <= '0;
            d_reg         <= '0;
            dt_reg        <= '0;
            den_reg       <= '0;
            num_reg       <= '0;
            acc_reg       <= '0;
            cand_reg      <= '0;
            sat_reg       <= 1'b0;
            integral_reg  <= '0;
            prev_reg      <= '0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            err_reg       <= err_next;
            nm_reg        <= nm_next;
            d_reg         <= d_next;
            dt_reg        <= dt_next;
            den_reg       <= den_next;
            num_reg       <= num_next;
            acc_reg       <= acc_next;
            cand_reg      <= cand_next;
            sat_reg       <= sat_next;
            integral_reg  <= integral_next;
            prev_reg      <= prev_next;
            div_start_reg <= div_start_next;
            mul_start_reg <= mul_start_next;
            mul_a_reg     <= mul_a_next;
            mul_b_reg     <= mul_b_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            bound_reg    <= '0;
            limit_reg    <= '0;
            mode_reg     <= pcs_pkg::DM_NONE;
            min_step_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pcs_pkg::CFG_PROP_GAIN:      kp_reg       <= cfg_data;
                pcs_pkg::CFG_INT_GAIN:       ki_reg       <= cfg_data;
                pcs_pkg::CFG_DERIV_GAIN:     kd_reg       <= cfg_data;
                pcs_pkg::CFG_INTEGRAL_BOUND: bound_reg    <= cfg_data[30:0];
                pcs_pkg::CFG_OUTPUT_LIMIT:   limit_reg    <= cfg_data[30:0];
                pcs_pkg::CFG_DERIV_MODE:     mode_reg     <= pcs_pkg::deriv_mode_t'(cfg_data[1:0]);
                pcs_pkg::CFG_MIN_STEP:       min_step_reg <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;
    assign cfg_ready    = 1'b1;

`ifndef ASSERT_OFF
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final step");

    a_sat_needs_ki: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && sat_reg) |-> ki_pos)
        else $error("saturation flagged with non-positive integral gain");

    a_mul_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid |-> (state_reg == S_MWAIT))
        else $error("multiplier result arrived while not waiting");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider result arrived while not waiting");
`endif

endmodule
